/* rtl/core/drws_pkg.sv */
// ----------------------------------------------------------------------------
// drws_pkg
// Shared types, register indexes and reset constants of the DAV/RFD sender.
// ----------------------------------------------------------------------------
package drws_pkg;

    localparam int BUS_WIDTH_DEF  = 15;
    localparam int TIMER_BITS_DEF = 24;

    localparam int DATA_BUS_W = 15;
    localparam int WORD_W     = 16;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int COUNT_W    = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RFD_ACTIVE_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFERS_ENABLED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ASSERT_TIMEOUT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEASSERT_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_WINDOW    = 3'd4;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] RST_ASSERT_TIMEOUT   = 24'd500000;
    localparam logic [CFG_DATA_W-1:0] RST_DEASSERT_TIMEOUT = 24'd500000;
    localparam logic [CFG_DATA_W-1:0] RST_CONNECT_WINDOW   = 24'd1000000;

    // Item operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEND = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE          = 2'd0,
        PH_WAIT_ASSERT   = 2'd1,
        PH_WAIT_DEASSERT = 2'd2
    } t_phase;

    // Transfer completion event for one item
    typedef struct packed {
        logic done;
        logic ok;
    } t_xfer_evt;

    typedef struct packed {
        logic [DATA_BUS_W-1:0] data_bus;
        logic                  dav_n;
        logic                  busy_res;
        logic                  word_done;
        logic                  word_ok;
        logic                  connected;
        logic [COUNT_W-1:0]    success_count;
        logic [COUNT_W-1:0]    failure_count;
    } t_result;

endpackage

/* rtl/core/drws_xfer.sv */
// ----------------------------------------------------------------------------
// drws_xfer
// Transfer sequencer: latches a word, waits on RFD, drives DAV and the bus.
// ----------------------------------------------------------------------------
module drws_xfer #(
    parameter int BUS_WIDTH  = drws_pkg::BUS_WIDTH_DEF,
    parameter int TIMER_BITS = drws_pkg::TIMER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic                            i_operation,
    input  logic [drws_pkg::WORD_W-1:0]     i_word,
    input  logic                            i_rfd_level,
    input  logic                            i_abort,
    input  logic                            i_rfd_active_low,
    input  logic                            i_enabled,
    input  logic [drws_pkg::CFG_DATA_W-1:0] i_assert_to,
    input  logic [drws_pkg::CFG_DATA_W-1:0] i_deassert_to,
    output logic [BUS_WIDTH-1:0]            o_n_bus,
    output logic                            o_n_dav,
    output logic                            o_n_busy,
    output drws_pkg::t_xfer_evt             o_evt
);

    drws_pkg::t_phase        r_phase, n_phase;
    logic [BUS_WIDTH-1:0]    r_held, n_held;
    logic [BUS_WIDTH-1:0]    r_bus, n_bus;
    logic                    r_dav, n_dav;
    logic [TIMER_BITS-1:0]   r_wait, n_wait;

    logic        asserted;
    logic [31:0] wait_ext;
    logic [31:0] limit_ext;
    logic        stop;
    logic        is_send;

    assign asserted  = i_rfd_active_low ? ~i_rfd_level : i_rfd_level;
    assign wait_ext  = 32'(r_wait);
    assign limit_ext = (r_phase == drws_pkg::PH_WAIT_ASSERT) ? 32'(i_assert_to)
                                                              : 32'(i_deassert_to);
    assign stop      = i_abort | ~i_enabled | (wait_ext > limit_ext);
    assign is_send   = (i_operation == drws_pkg::OP_SEND);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_fire) begin
            case (r_phase)
                drws_pkg::PH_WAIT_ASSERT: begin
                    if (!is_send) begin
                        if (asserted) begin
                            n_phase = drws_pkg::PH_WAIT_DEASSERT;
                        end else if (stop) begin
                            n_phase = drws_pkg::PH_IDLE;
                        end
                    end
                end
                drws_pkg::PH_WAIT_DEASSERT: begin
                    if (!is_send && (!asserted || stop)) begin
                        n_phase = drws_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = (is_send && i_enabled) ? drws_pkg::PH_WAIT_ASSERT
                                                     : drws_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Datapath and completion event
    always_comb begin
        n_held    = r_held;
        n_bus     = r_bus;
        n_dav     = r_dav;
        n_wait    = r_wait;
        o_evt     = '0;
        if (i_fire) begin
            case (r_phase)
                drws_pkg::PH_WAIT_ASSERT: begin
                    if (!is_send) begin
                        if (asserted) begin
                            n_bus  = r_held;
                            n_dav  = 1'b0;
                            n_wait = '0;
                        end else if (stop) begin
                            n_dav      = 1'b1;
                            n_wait     = '0;
                            o_evt.done = 1'b1;
                        end else if (r_wait != '1) begin
                            n_wait = r_wait + 1'b1;
                        end
                    end
                end
                drws_pkg::PH_WAIT_DEASSERT: begin
                    if (!is_send) begin
                        if (!asserted) begin
                            n_dav      = 1'b1;
                            n_wait     = '0;
                            o_evt.done = 1'b1;
                            o_evt.ok   = 1'b1;
                        end else if (stop) begin
                            n_dav      = 1'b1;
                            n_wait     = '0;
                            o_evt.done = 1'b1;
                        end else if (r_wait != '1) begin
                            n_wait = r_wait + 1'b1;
                        end
                    end
                end
                default: begin
                    if (is_send) begin
                        if (!i_enabled) begin
                            n_dav      = 1'b1;
                            n_wait     = '0;
                            o_evt.done = 1'b1;
                        end else begin
                            n_held = i_word[BUS_WIDTH-1:0];
                            n_wait = '0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= drws_pkg::PH_IDLE;
            r_held  <= '0;
            r_bus   <= '0;
            r_dav   <= 1'b1;
            r_wait  <= '0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_bus   <= n_bus;
            r_dav   <= n_dav;
            r_wait  <= n_wait;
        end
    end

    assign o_n_bus  = n_bus;
    assign o_n_dav  = n_dav;
    assign o_n_busy = (n_phase != drws_pkg::PH_IDLE);

endmodule

/* rtl/core/drws_link.sv */
// ----------------------------------------------------------------------------
// drws_link
// Link statistics: success and failure counts and the connected flag.
// ----------------------------------------------------------------------------
module drws_link #(
    parameter int TIMER_BITS = drws_pkg::TIMER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_tick,
    input  drws_pkg::t_xfer_evt             i_evt,
    input  logic [drws_pkg::CFG_DATA_W-1:0] i_window,
    output logic                            o_n_connected,
    output logic [drws_pkg::COUNT_W-1:0]    o_n_ok_total,
    output logic [drws_pkg::COUNT_W-1:0]    o_n_fail_total
);

    logic [TIMER_BITS-1:0]        r_since, n_since;
    logic [TIMER_BITS-1:0]        since_tick;
    logic                         r_ever, n_ever;
    logic                         r_link, n_link;
    logic [drws_pkg::COUNT_W-1:0] r_ok, n_ok;
    logic [drws_pkg::COUNT_W-1:0] r_fail, n_fail;
    logic                         stale;

    // Advance the age counter first, saturating
    assign since_tick = (i_tick && r_since != '1) ? r_since + 1'b1 : r_since;
    assign stale      = ~r_ever | (32'(since_tick) > 32'(i_window));

    always_comb begin
        n_since = since_tick;
        n_ever  = r_ever;
        n_link  = r_link;
        n_ok    = r_ok;
        n_fail  = r_fail;
        if (i_evt.done) begin
            if (i_evt.ok) begin
                n_since = '0;
                n_ever  = 1'b1;
                n_link  = 1'b1;
                n_ok    = r_ok + 1'b1;
            end else begin
                n_fail = r_fail + 1'b1;
                if (stale) begin
                    n_link = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= '0;
            r_ever  <= 1'b0;
            r_link  <= 1'b0;
            r_ok    <= '0;
            r_fail  <= '0;
        end else begin
            r_since <= n_since;
            r_ever  <= n_ever;
            r_link  <= n_link;
            r_ok    <= n_ok;
            r_fail  <= n_fail;
        end
    end

    assign o_n_connected  = n_link;
    assign o_n_ok_total   = n_ok;
    assign o_n_fail_total = n_fail;

endmodule

/* rtl/core/drws_obuf.sv */
// ----------------------------------------------------------------------------
// drws_obuf
// Result register with a skid entry; parts the input and output handshakes.
// ----------------------------------------------------------------------------
module drws_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  drws_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output drws_pkg::t_result o_data
);

    logic              r_ov, n_ov;
    logic              r_sv, n_sv;
    drws_pkg::t_result r_out, n_out;
    drws_pkg::t_result r_skid, n_skid;
    logic              pop;

    assign pop = r_ov & ~i_stall;

    always_comb begin
        n_ov   = r_ov;
        n_sv   = r_sv;
        n_out  = r_out;
        n_skid = r_skid;
        if (!r_ov || pop) begin
            if (r_sv) begin
                n_out = r_skid;
                n_ov  = 1'b1;
                n_sv  = i_push;
                if (i_push) begin
                    n_skid = i_data;
                end
            end else if (i_push) begin
                n_out = i_data;
                n_ov  = 1'b1;
            end else begin
                n_ov = 1'b0;
            end
        end else if (i_push) begin
            n_skid = i_data;
            n_sv   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full  = r_sv;
    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

/* rtl/core/dav_rfd_word_handshake_sender_core.sv */
// ----------------------------------------------------------------------------
// dav_rfd_word_handshake_sender_core
// Output: each result beat is registered in the output register, or in the skid entry while stalled.
// Throughput: one item per cycle unless the skid entry is full; the sequencer and counters update each beat.
// A skid entry keeps input flowing for one beat while the output is stalled.
// Reset (synchronous, active low): idle, DAV released, counts and flags zero,
// configuration back to its defaults.
// ----------------------------------------------------------------------------
//
// Each accepted beat is either a one-microsecond tick or a send request.
// A send latches the word and starts a transfer; ticks then walk the wait
// for RFD asserted, drive the bus and pull DAV low, then wait for RFD to
// drop and release DAV. Both waits time out, and abort or disabling ends a
// wait as a failure. All state updates for a beat are made in the same
// cycle it is accepted; the result beat is captured into the output stage.
// ----------------------------------------------------------------------------
module dav_rfd_word_handshake_sender_core #(
    parameter int BUS_WIDTH  = drws_pkg::BUS_WIDTH_DEF,
    parameter int TIMER_BITS = drws_pkg::TIMER_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [drws_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [drws_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic [drws_pkg::WORD_W-1:0]       i_word,
    input  logic                              i_rfd_level,
    input  logic                              i_abort,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [drws_pkg::DATA_BUS_W-1:0]   o_data_bus,
    output logic                              o_dav_n,
    output logic                              o_busy_res,
    output logic                              o_word_done,
    output logic                              o_word_ok,
    output logic                              o_connected,
    output logic [drws_pkg::COUNT_W-1:0]      o_success_count,
    output logic [drws_pkg::COUNT_W-1:0]      o_failure_count
);

    // Configuration registers
    logic                            r_rfd_active_low;
    logic                            r_enabled;
    logic [drws_pkg::CFG_DATA_W-1:0] r_assert_to;
    logic [drws_pkg::CFG_DATA_W-1:0] r_deassert_to;
    logic [drws_pkg::CFG_DATA_W-1:0] r_window;

    logic                            fire;
    logic                            tick;
    logic                            obuf_full;
    logic [BUS_WIDTH-1:0]            n_bus;
    logic [drws_pkg::WORD_W-1:0]     bus_ext;
    logic                            n_dav;
    logic                            n_busy;
    logic                            n_connected;
    logic [drws_pkg::COUNT_W-1:0]    n_ok_total;
    logic [drws_pkg::COUNT_W-1:0]    n_fail_total;
    drws_pkg::t_xfer_evt             evt;
    drws_pkg::t_result               res_in;
    drws_pkg::t_result               res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rfd_active_low <= 1'b0;
            r_enabled        <= 1'b1;
            r_assert_to      <= drws_pkg::RST_ASSERT_TIMEOUT;
            r_deassert_to    <= drws_pkg::RST_DEASSERT_TIMEOUT;
            r_window         <= drws_pkg::RST_CONNECT_WINDOW;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                drws_pkg::CFG_RFD_ACTIVE_LOW:    r_rfd_active_low <= i_cfg_data[0];
                drws_pkg::CFG_TRANSFERS_ENABLED: r_enabled        <= i_cfg_data[0];
                drws_pkg::CFG_ASSERT_TIMEOUT:    r_assert_to      <= i_cfg_data;
                drws_pkg::CFG_DEASSERT_TIMEOUT:  r_deassert_to    <= i_cfg_data;
                drws_pkg::CFG_CONNECT_WINDOW:    r_window         <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Hold input only when both output slots are taken
    assign o_in_stall = obuf_full;
    assign fire       = i_in_valid & ~obuf_full;
    assign tick       = fire & (i_operation == drws_pkg::OP_TICK);

    drws_xfer #(
        .BUS_WIDTH  (BUS_WIDTH),
        .TIMER_BITS (TIMER_BITS)
    ) u_xfer (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_operation      (i_operation),
        .i_word           (i_word),
        .i_rfd_level      (i_rfd_level),
        .i_abort          (i_abort),
        .i_rfd_active_low (r_rfd_active_low),
        .i_enabled        (r_enabled),
        .i_assert_to      (r_assert_to),
        .i_deassert_to    (r_deassert_to),
        .o_n_bus          (n_bus),
        .o_n_dav          (n_dav),
        .o_n_busy         (n_busy),
        .o_evt            (evt)
    );

    drws_link #(
        .TIMER_BITS (TIMER_BITS)
    ) u_link (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (tick),
        .i_evt          (evt),
        .i_window       (r_window),
        .o_n_connected  (n_connected),
        .o_n_ok_total   (n_ok_total),
        .o_n_fail_total (n_fail_total)
    );

    // The bus field carries only the low 15 bits of the driven word
    assign bus_ext = drws_pkg::WORD_W'(n_bus);

    always_comb begin
        res_in.data_bus      = bus_ext[drws_pkg::DATA_BUS_W-1:0];
        res_in.dav_n         = n_dav;
        res_in.busy_res      = n_busy;
        res_in.word_done     = evt.done;
        res_in.word_ok       = evt.ok;
        res_in.connected     = n_connected;
        res_in.success_count = n_ok_total;
        res_in.failure_count = n_fail_total;
    end

    drws_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (res_in),
        .o_full  (obuf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (res_out)
    );

    assign o_data_bus      = res_out.data_bus;
    assign o_dav_n         = res_out.dav_n;
    assign o_busy_res      = res_out.busy_res;
    assign o_word_done     = res_out.word_done;
    assign o_word_ok       = res_out.word_ok;
    assign o_connected     = res_out.connected;
    assign o_success_count = res_out.success_count;
    assign o_failure_count = res_out.failure_count;

endmodule

/* tb/dav_rfd_word_handshake_sender_core_tb.sv */
// ----------------------------------------------------------------------------
// dav_rfd_word_handshake_sender_core_tb
// Self-checking bench for the DAV/RFD word sender core. Directed beats walk
// a good transfer, aborts, both timeouts, disabled sends and the connected
// window. Random beats then run whole transfers with random word content,
// RFD timing, aborts and noise under several register settings and under
// sender gaps and receiver stalls. An in-bench predictor keeps its own copy
// of the sequencer state and every result beat is checked field by field.
// ----------------------------------------------------------------------------
module dav_rfd_word_handshake_sender_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SEG_ITEMS     = 76;
    localparam logic [23:0] T_MAX = 24'hFFFFFF;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------------
    logic                            i_clk   = 1'b0;
    logic                            i_rst_n = 1'b0;

    logic                            i_cfg_we    = 1'b0;
    logic [drws_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [drws_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic                            i_in_valid  = 1'b0;
    logic                            o_in_stall;
    logic                            i_operation = drws_pkg::OP_TICK;
    logic [drws_pkg::WORD_W-1:0]     i_word      = '0;
    logic                            i_rfd_level = 1'b0;
    logic                            i_abort     = 1'b0;

    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [drws_pkg::DATA_BUS_W-1:0] o_data_bus;
    logic                            o_dav_n;
    logic                            o_busy_res;
    logic                            o_word_done;
    logic                            o_word_ok;
    logic                            o_connected;
    logic [drws_pkg::COUNT_W-1:0]    o_success_count;
    logic [drws_pkg::COUNT_W-1:0]    o_failure_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    dav_rfd_word_handshake_sender_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_word          (i_word),
        .i_rfd_level     (i_rfd_level),
        .i_abort         (i_abort),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_data_bus      (o_data_bus),
        .o_dav_n         (o_dav_n),
        .o_busy_res      (o_busy_res),
        .o_word_done     (o_word_done),
        .o_word_ok       (o_word_ok),
        .o_connected     (o_connected),
        .o_success_count (o_success_count),
        .o_failure_count (o_failure_count)
    );

    // ------------------------------------------------------------------------
    // Bench copy of the registers and the sequencer state
    // ------------------------------------------------------------------------
    logic        cfg_rfd_low;
    logic        cfg_enabled;
    logic [23:0] cfg_assert_to;
    logic [23:0] cfg_deassert_to;
    logic [23:0] cfg_window;

    drws_pkg::t_phase                xfer_phase;
    logic [drws_pkg::DATA_BUS_W-1:0] latched_word;
    logic [drws_pkg::DATA_BUS_W-1:0] bus_word;
    logic                            dav_line;
    logic [23:0]                     wait_count;
    logic [23:0]                     ticks_since_ok;
    logic                            had_success;
    logic                            link_flag;
    logic [drws_pkg::COUNT_W-1:0]    good_words;
    logic [drws_pkg::COUNT_W-1:0]    bad_words;

    drws_pkg::t_result pending_results[$];

    int unsigned err_count    = 0;
    int unsigned beats_in     = 0;    // accepted beats that were not ignored
    int unsigned beats_out    = 0;
    int unsigned cfg_loads    = 0;
    int unsigned cycle_count  = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct       = 0;

    function automatic logic [23:0] bump_sat(input logic [23:0] v);
        return (v == T_MAX) ? v : v + 24'd1;
    endfunction

    // Raw RFD level that reads as asserted (or not) under the current polarity
    function automatic logic rfd_reading(input logic want_asserted);
        return cfg_rfd_low ? ~want_asserted : want_asserted;
    endfunction

    task automatic reset_sender_state();
        cfg_rfd_low     = 1'b0;
        cfg_enabled     = 1'b1;
        cfg_assert_to   = drws_pkg::RST_ASSERT_TIMEOUT;
        cfg_deassert_to = drws_pkg::RST_DEASSERT_TIMEOUT;
        cfg_window      = drws_pkg::RST_CONNECT_WINDOW;
        xfer_phase      = drws_pkg::PH_IDLE;
        latched_word    = '0;
        bus_word        = '0;
        dav_line        = 1'b1;
        wait_count      = '0;
        ticks_since_ok  = '0;
        had_success     = 1'b0;
        link_flag       = 1'b0;
        good_words      = '0;
        bad_words       = '0;
    endtask

    task automatic end_transfer(input logic success);
        dav_line   = 1'b1;
        xfer_phase = drws_pkg::PH_IDLE;
        wait_count = '0;
        if (success) begin
            good_words     = good_words + 1;
            ticks_since_ok = '0;
            had_success    = 1'b1;
            link_flag      = 1'b1;
        end else begin
            bad_words = bad_words + 1;
            // drop the link only when no recent success vouches for it
            if (!had_success || ticks_since_ok > cfg_window)
                link_flag = 1'b0;
        end
    endtask

    // Advance the sender state by one beat and queue the result it yields
    task automatic advance_sender(input logic op, input logic [drws_pkg::WORD_W-1:0] word,
                                  input logic rfd, input logic abrt,
                                  output logic ignored);
        logic              asserted;
        logic              done;
        logic              ok;
        drws_pkg::t_result r;
        asserted = cfg_rfd_low ? ~rfd : rfd;
        done     = 1'b0;
        ok       = 1'b0;
        ignored  = 1'b0;
        if (op == drws_pkg::OP_SEND) begin
            if (xfer_phase == drws_pkg::PH_IDLE) begin
                if (!cfg_enabled) begin
                    end_transfer(1'b0);
                    done = 1'b1;
                end else begin
                    latched_word = word[drws_pkg::DATA_BUS_W-1:0];
                    xfer_phase   = drws_pkg::PH_WAIT_ASSERT;
                    wait_count   = '0;
                end
            end else begin
                ignored = 1'b1;
            end
        end else begin
            ticks_since_ok = bump_sat(ticks_since_ok);
            case (xfer_phase)
                drws_pkg::PH_WAIT_ASSERT: begin
                    if (asserted) begin
                        bus_word   = latched_word;
                        dav_line   = 1'b0;
                        xfer_phase = drws_pkg::PH_WAIT_DEASSERT;
                        wait_count = '0;
                    end else if (abrt || !cfg_enabled || wait_count > cfg_assert_to) begin
                        end_transfer(1'b0);
                        done = 1'b1;
                    end else begin
                        wait_count = bump_sat(wait_count);
                    end
                end
                drws_pkg::PH_WAIT_DEASSERT: begin
                    if (!asserted) begin
                        end_transfer(1'b1);
                        done = 1'b1;
                        ok   = 1'b1;
                    end else if (abrt || !cfg_enabled || wait_count > cfg_deassert_to) begin
                        end_transfer(1'b0);
                        done = 1'b1;
                    end else begin
                        wait_count = bump_sat(wait_count);
                    end
                end
                default: ;
            endcase
        end
        r.data_bus      = bus_word;
        r.dav_n         = dav_line;
        r.busy_res      = (xfer_phase != drws_pkg::PH_IDLE);
        r.word_done     = done;
        r.word_ok       = ok;
        r.connected     = link_flag;
        r.success_count = good_words;
        r.failure_count = bad_words;
        pending_results.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Input side: one beat per call, with random gaps ahead of it
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic op, input logic [drws_pkg::WORD_W-1:0] word,
                             input logic rfd, input logic abrt);
        logic ignored;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_word      <= word;
        i_rfd_level <= rfd;
        i_abort     <= abrt;
        // hold the payload until the DUT takes it
        do @(posedge i_clk); while (o_in_stall);
        advance_sender(op, word, rfd, abrt, ignored);
        if (!ignored)
            beats_in++;
    endtask

    // Drop valid and wait out every outstanding result plus the output stage
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write all five registers; one-bit registers get random upper bits
    task automatic load_config(input logic ral, input logic en, input logic [23:0] a_to,
                               input logic [23:0] d_to, input logic [23:0] win);
        wait_for_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= drws_pkg::CFG_RFD_ACTIVE_LOW;
        i_cfg_data  <= {23'($urandom_range(8388607)), ral};
        @(posedge i_clk);
        cfg_rfd_low = ral;
        i_cfg_index <= drws_pkg::CFG_TRANSFERS_ENABLED;
        i_cfg_data  <= {23'($urandom_range(8388607)), en};
        @(posedge i_clk);
        cfg_enabled = en;
        i_cfg_index <= drws_pkg::CFG_ASSERT_TIMEOUT;
        i_cfg_data  <= a_to;
        @(posedge i_clk);
        cfg_assert_to = a_to;
        i_cfg_index <= drws_pkg::CFG_DEASSERT_TIMEOUT;
        i_cfg_data  <= d_to;
        @(posedge i_clk);
        cfg_deassert_to = d_to;
        i_cfg_index <= drws_pkg::CFG_CONNECT_WINDOW;
        i_cfg_data  <= win;
        @(posedge i_clk);
        cfg_window = win;
        i_cfg_we <= 1'b0;
        cfg_loads++;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall and result checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        drws_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_out++;
            if (pending_results.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, actual bus 0x%0h",
                         $time, o_data_bus);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("data_bus", 32'(want.data_bus), 32'(o_data_bus));
                check_field("dav_n", 32'(want.dav_n), 32'(o_dav_n));
                check_field("busy_res", 32'(want.busy_res), 32'(o_busy_res));
                check_field("word_done", 32'(want.word_done), 32'(o_word_done));
                check_field("word_ok", 32'(want.word_ok), 32'(o_word_ok));
                check_field("connected", 32'(want.connected), 32'(o_connected));
                check_field("success_count", want.success_count, o_success_count);
                check_field("failure_count", want.failure_count, o_failure_count);
            end
        end
    end

    // Watchdog: end the run as failed once cycle_count reaches CYCLE_LIMIT
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: watchdog expired with %0d results outstanding",
                     $time, pending_results.size());
            $display("dav_rfd_word_handshake_sender_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Default polarity: level 1 reads asserted
    task automatic test_basic_transfer();
        load_config(1'b0, 1'b1, drws_pkg::RST_ASSERT_TIMEOUT,
                    drws_pkg::RST_DEASSERT_TIMEOUT, drws_pkg::RST_CONNECT_WINDOW);
        send_beat(drws_pkg::OP_TICK, 16'h0000, 1'b0, 1'b1);   // abort with nothing to abort
        send_beat(drws_pkg::OP_SEND, 16'hFFFF, 1'b0, 1'b0);
        send_beat(drws_pkg::OP_SEND, 16'h1234, 1'b1, 1'b1);   // busy: dropped
        send_beat(drws_pkg::OP_TICK, 16'h0000, 1'b0, 1'b0);
        send_beat(drws_pkg::OP_TICK, 16'h0000, 1'b1, 1'b0);   // RFD up: bus driven, DAV low
        send_beat(drws_pkg::OP_TICK, 16'hFFFF, 1'b1, 1'b0);
        send_beat(drws_pkg::OP_TICK, 16'h0000, 1'b0, 1'b0);   // RFD down: success
    endtask

    // Abort in each wait; a recent success keeps the link up
    task automatic test_abort();
        send_beat(drws_pkg::OP_SEND, 16'h0000, 1'b1, 1'b1);
        send_beat(drws_pkg::OP_TICK, 16'h0000, 1'b1, 1'b0);
        send_beat(drws_pkg::OP_TICK, 16'h0000, 1'b1, 1'b1);
        send_beat(drws_pkg::OP_SEND, 16'h8000, 1'b0, 1'b0);
        send_beat(drws_pkg::OP_TICK, 16'hFFFF, 1'b0, 1'b1);
    endtask

    // Zero timeouts and window under active-low RFD
    task automatic test_timeouts();
        load_config(1'b1, 1'b1, 24'd0, 24'd0, 24'd0);
        send_beat(drws_pkg::OP_SEND, 16'h7FFF, 1'b0, 1'b0);
        send_beat(drws_pkg::OP_TICK, 16'h0000, 1'b1, 1'b0);
        send_beat(drws_pkg::OP_TICK, 16'h0000, 1'b1, 1'b0);   // assert wait expires
        send_beat(drws_pkg::OP_SEND, 16'h5555, 1'b0, 1'b0);
        send_beat(drws_pkg::OP_TICK, 16'h0000, 1'b0, 1'b0);
        send_beat(drws_pkg::OP_TICK, 16'h0000, 1'b0, 1'b0);
        send_beat(drws_pkg::OP_TICK, 16'h0000, 1'b0, 1'b0);   // deassert wait expires
        send_beat(drws_pkg::OP_SEND, 16'h2AAA, 1'b1, 1'b0);
        send_beat(drws_pkg::OP_TICK, 16'h0000, 1'b0, 1'b0);
        send_beat(drws_pkg::OP_TICK, 16'h0000, 1'b1, 1'b0);
    endtask

    // Disabled sends fail at once; full-scale window holds the link
    task automatic test_disabled_and_window();
        load_config(1'b0, 1'b0, T_MAX, T_MAX, T_MAX);
        send_beat(drws_pkg::OP_SEND, 16'hFFFF, 1'b1, 1'b1);
        send_beat(drws_pkg::OP_TICK, 16'hFFFF, 1'b1, 1'b1);
        load_config(1'b0, 1'b1, T_MAX, T_MAX, T_MAX);
        send_beat(drws_pkg::OP_SEND, 16'h00FF, 1'b0, 1'b0);
        send_beat(drws_pkg::OP_TICK, 16'h0000, 1'b0, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------------

    // One send followed by a run of RFD deasserted, a run of RFD asserted and a drop,
    // with random run lengths that can reach just past each timeout no larger than 28
    task automatic drive_transfer();
        int unsigned lim_a;
        int unsigned lim_d;
        int unsigned n_pre;
        int unsigned n_hold;
        int unsigned total;
        int unsigned abort_at;
        int unsigned k;
        logic        lvl;
        lim_a  = (cfg_assert_to > 24'd28) ? 30 : 32'(cfg_assert_to) + 2;
        lim_d  = (cfg_deassert_to > 24'd28) ? 30 : 32'(cfg_deassert_to) + 2;
        n_pre  = $urandom_range(lim_a);
        n_hold = $urandom_range(lim_d);
        total  = n_pre + n_hold + 1;
        abort_at = ($urandom_range(9) == 0) ? $urandom_range(total - 1) : total;
        send_beat(drws_pkg::OP_SEND, 16'($urandom), 1'($urandom), 1'($urandom));
        for (k = 0; k < total; k++) begin
            if ($urandom_range(19) == 0)
                send_beat(drws_pkg::OP_SEND, 16'($urandom), 1'($urandom), 1'($urandom));
            if (k < n_pre)
                lvl = rfd_reading(1'b0);
            else if (k < n_pre + n_hold)
                lvl = rfd_reading(1'b1);
            else
                lvl = rfd_reading(1'b0);
            // a rare glitch on RFD breaks the run
            if ($urandom_range(31) == 0)
                lvl = ~lvl;
            send_beat(drws_pkg::OP_TICK, 16'($urandom), lvl, k == abort_at);
        end
        // idle ticks between words age the last success against the window
        if ($urandom_range(3) == 0) begin
            total = (cfg_window > 24'd38) ? $urandom_range(40)
                                          : $urandom_range(32'(cfg_window) + 2);
            for (k = 0; k < total; k++)
                send_beat(drws_pkg::OP_TICK, 16'($urandom), 1'($urandom),
                          $urandom_range(7) == 0);
        end
    endtask

    function automatic logic [23:0] pick_limit();
        case ($urandom_range(5))
            0:       return 24'd0;
            1:       return T_MAX;
            2:       return 24'($urandom_range(60));
            default: return 24'($urandom_range(12));
        endcase
    endfunction

    task automatic test_random_traffic();
        int unsigned mode;
        int unsigned seg;
        int unsigned target;
        for (mode = 0; mode < 4; mode++) begin
            case (mode)
                0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
                1:       begin sender_idle_pct = 54; stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  stall_pct = 54; end
                default: begin sender_idle_pct = 30; stall_pct = 30; end
            endcase
            for (seg = 0; seg < 4; seg++) begin
                if (seg == 0)
                    load_config(1'($urandom), 1'b1, 24'd0, 24'd0, 24'd0);
                else if (seg == 1)
                    load_config(1'($urandom), 1'b1, T_MAX, T_MAX, T_MAX);
                else
                    load_config(1'($urandom), $urandom_range(9) != 0, pick_limit(),
                                pick_limit(), pick_limit());
                target = beats_in + SEG_ITEMS;
                while (beats_in < target)
                    drive_transfer();
            end
        end
        sender_idle_pct = 0;
        stall_pct       = 0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_sender_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_transfer();
        test_abort();
        test_timeouts();
        test_disabled_and_window();
        test_random_traffic();

        wait_for_idle();
        repeat (5) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived",
                     $time, pending_results.size());
            err_count++;
        end

        $display("Ran %0d beats through %0d register loads, checked %0d results.",
                 beats_in, cfg_loads, beats_out);
        $display("Predicted %0d good words and %0d failed transfers, %0d mismatches.",
                 good_words, bad_words, err_count);
        if (err_count == 0)
            $display("dav_rfd_word_handshake_sender_core test passed");
        else
            $display("dav_rfd_word_handshake_sender_core test failed");
        $finish;
    end

endmodule
